// ----- hdl/qnl_pkg.sv -----
// Shared constants and types for the quaternion normalized-blend unit.
// No dependencies; imported by every module of the block.
package qnl_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int BLEND_W = 15;
    localparam int BLEND_FRAC = 14;
    localparam int BLEND_HALF = 8192;
    localparam logic [BLEND_W-1:0] BLEND_ONE = 15'd16384;
    localparam int THRESH_W = 20;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd256;
    localparam int LEN_MAX_W = 64;

    typedef struct packed {
        logic valid;
        logic degen;
    } ctl_t;

endpackage

// ----- hdl/qnl_sqrt_cell.sv -----
// One cell of the square-root chain: retires one root bit from two length bits.
// Depends on qnl_pkg.
module qnl_sqrt_cell #(
    parameter int CW  = 16,
    parameter int SW  = 17,
    parameter int IDX = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  qnl_pkg::ctl_t            ctl_i,
    input  logic [2*SW-1:0]          len_i,
    input  logic [3:0][CW-1:0]       mix_i,
    input  logic [SW-1:0]            root_i,
    input  logic [SW+1:0]            rem_i,
    output qnl_pkg::ctl_t            ctl_o,
    output logic [2*SW-1:0]          len_o,
    output logic [3:0][CW-1:0]       mix_o,
    output logic [SW-1:0]            root_o,
    output logic [SW+1:0]            rem_o
);
    import qnl_pkg::*;

    ctl_t              ctl_reg;
    logic [2*SW-1:0]   len_reg;
    logic [3:0][CW-1:0] mix_reg;
    logic [SW-1:0]     root_reg, root_next;
    logic [SW+1:0]     rem_reg, rem_next;
    logic [SW+3:0]     rem4, trial;

    always_comb begin
        rem4  = {rem_i, len_i[2*IDX+1 -: 2]};
        trial = (SW+4)'({root_i, 2'b01});
        if (rem4 >= trial) begin
            rem_next  = (SW+2)'(rem4 - trial);
            root_next = {root_i[SW-2:0], 1'b1};
        end else begin
            rem_next  = (SW+2)'(rem4);
            root_next = {root_i[SW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            len_reg  <= len_i;
            mix_reg  <= mix_i;
            root_reg <= root_next;
            rem_reg  <= rem_next;
        end
    end

    assign ctl_o  = ctl_reg;
    assign len_o  = len_reg;
    assign mix_o  = mix_reg;
    assign root_o = root_reg;
    assign rem_o  = rem_reg;

endmodule

// ----- hdl/qnl_div_cell.sv -----
// One cell of the divider chain: retires one quotient bit on all four lanes.
// Depends on qnl_pkg.
module qnl_div_cell #(
    parameter int NW = 32,
    parameter int QB = 15,
    parameter int SW = 17,
    parameter int K  = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  qnl_pkg::ctl_t        ctl_i,
    input  logic [SW:0]          den_i,
    input  logic [3:0]           neg_i,
    input  logic [3:0]           ovf_i,
    input  logic [3:0][NW-1:0]   rem_i,
    input  logic [3:0][QB-1:0]   quo_i,
    output qnl_pkg::ctl_t        ctl_o,
    output logic [SW:0]          den_o,
    output logic [3:0]           neg_o,
    output logic [3:0]           ovf_o,
    output logic [3:0][NW-1:0]   rem_o,
    output logic [3:0][QB-1:0]   quo_o
);
    import qnl_pkg::*;

    localparam int CMPW = NW + SW + 2;

    ctl_t               ctl_reg;
    logic [SW:0]        den_reg;
    logic [3:0]         neg_reg, ovf_reg;
    logic [3:0][NW-1:0] rem_reg, rem_next;
    logic [3:0][QB-1:0] quo_reg, quo_next;
    logic [CMPW-1:0]    dsh;

    always_comb begin
        dsh = CMPW'(den_i) << K;
        for (int l = 0; l < 4; l++) begin
            if (CMPW'(rem_i[l]) >= dsh) begin
                rem_next[l] = NW'(CMPW'(rem_i[l]) - dsh);
                quo_next[l] = quo_i[l] | (QB'(1) << K);
            end else begin
                rem_next[l] = rem_i[l];
                quo_next[l] = quo_i[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            den_reg <= den_i;
            neg_reg <= neg_i;
            ovf_reg <= ovf_i;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign ctl_o = ctl_reg;
    assign den_o = den_reg;
    assign neg_o = neg_reg;
    assign ovf_o = ovf_reg;
    assign rem_o = rem_reg;
    assign quo_o = quo_reg;

endmodule

// ----- hdl/quaternion_nlerp_unit.sv -----
// Top level of the quaternion normalized-blend unit: mix, length, root and divider chains.
// Depends on qnl_pkg, qnl_sqrt_cell and qnl_div_cell.
//
// Usage: a word on s_ carries from (x,y,z,w), to (x,y,z,w) and the blend factor.
// Each accepted word yields exactly one result word on m_: the unit-length blend
// in Q2.14, with m_tuser set when the mix was too short and identity was sent.
// The zero threshold is written on the cfg_ channel; the user must do so only while
// the unit is idle, as the block itself does not enforce it.
// The root chain yields SW root bits, SW being half the padded length width (17), and
// the divider chain yields QB quotient bits (15).
// Throughput: one word per cycle while the output is not stalled, set by the chain of
// root cells (one root bit per cell) and the chain of divider cells (one quotient bit
// per cell). All stages advance together; when m_tready is low with a result waiting,
// the pipeline holds and s_tready drops in the same cycle.
// Reset (aresetn low, synchronous) empties the pipeline and sets the threshold to 256.
module quaternion_nlerp_unit #(
    parameter int COMP_WIDTH = qnl_pkg::COMP_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w, blend
    input  logic [((8*COMP_WIDTH+qnl_pkg::BLEND_W+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // out_x, out_y, out_z, out_w
    output logic [((4*COMP_WIDTH+7)/8)*8-1:0] m_tdata,
    // degenerate
    output logic m_tuser,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [qnl_pkg::THRESH_W-1:0] cfg_data
);
    import qnl_pkg::*;

    localparam int CW   = COMP_WIDTH;
    localparam int F    = CW - 2;
    localparam int PW   = CW + BLEND_W + 3;
    localparam int LW   = 2*CW + 2;
    localparam int LCW  = (LW > LEN_MAX_W) ? LEN_MAX_W : LW;
    localparam int SW   = (LCW + 1) / 2;
    localparam int LPW  = 2 * SW;
    localparam int QB   = F + 1;
    localparam int NW   = CW + F + 2;
    localparam int CMPW = NW + SW + 2;
    localparam int OW   = ((4*CW+7)/8)*8;
    localparam logic [QB-1:0] ONE_Q = QB'(1) << F;
    localparam logic [CW-1:0] ONE_C = CW'(1) << F;

    logic adv;
    logic [THRESH_W-1:0] thresh_reg;

    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_valid) begin
            thresh_reg <= cfg_data;
        end
    end

    // mix stage
    logic [BLEND_W-1:0]  blend_c;
    logic signed [PW-1:0] a_e [4];
    logic signed [PW-1:0] b_e [4];
    logic signed [PW-1:0] p_e [4];
    logic [3:0][CW-1:0]  mix_c, mix_reg;
    ctl_t                c1_reg;

    always_comb begin
        blend_c = s_tdata[8*CW +: BLEND_W];
        if (blend_c > BLEND_ONE) begin
            blend_c = BLEND_ONE;
        end
        for (int l = 0; l < 4; l++) begin
            a_e[l]   = PW'($signed(s_tdata[l*CW +: CW]));
            b_e[l]   = PW'($signed(s_tdata[(l+4)*CW +: CW]));
            p_e[l]   = (b_e[l] - a_e[l]) * $signed({1'b0, blend_c}) + PW'(BLEND_HALF);
            mix_c[l] = CW'(a_e[l] + (p_e[l] >>> BLEND_FRAC));
        end
    end

    // square stage
    logic [3:0][CW-1:0]   mag_c, mix2_reg;
    logic [3:0][2*CW-1:0] sq_reg;
    ctl_t                 c2_reg;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            mag_c[l] = mix_reg[l][CW-1] ? CW'(-mix_reg[l]) : mix_reg[l];
        end
    end

    // sum stage
    logic [LW-1:0]      sum_c;
    logic [LCW-1:0]     lsat_c;
    logic [LPW-1:0]     len_c, len_reg;
    logic [3:0][CW-1:0] mix3_reg;
    ctl_t               c3_reg;

    always_comb begin
        sum_c = LW'(sq_reg[0]) + LW'(sq_reg[1]) + LW'(sq_reg[2]) + LW'(sq_reg[3]);
        lsat_c = ((sum_c >> LCW) != '0) ? '1 : sum_c[LCW-1:0];
        len_c = LPW'(lsat_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end else if (adv) begin
            c1_reg.valid <= s_tvalid;
            c1_reg.degen <= 1'b0;
            c2_reg       <= c1_reg;
            c3_reg.valid <= c2_reg.valid;
            c3_reg.degen <= len_c <= LPW'(thresh_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mix_reg  <= mix_c;
            mix2_reg <= mix_reg;
            for (int l = 0; l < 4; l++) begin
                sq_reg[l] <= (2*CW)'(mag_c[l]) * (2*CW)'(mag_c[l]);
            end
            mix3_reg <= mix2_reg;
            len_reg  <= len_c;
        end
    end

    // root chain
    ctl_t               sq_ctl  [SW+1];
    logic [LPW-1:0]     sq_len  [SW+1];
    logic [3:0][CW-1:0] sq_mix  [SW+1];
    logic [SW-1:0]      sq_root [SW+1];
    logic [SW+1:0]      sq_rem  [SW+1];

    assign sq_ctl[0]  = c3_reg;
    assign sq_len[0]  = len_reg;
    assign sq_mix[0]  = mix3_reg;
    assign sq_root[0] = '0;
    assign sq_rem[0]  = '0;

    for (genvar i = 0; i < SW; i++) begin : g_sqrt
        qnl_sqrt_cell #(.CW(CW), .SW(SW), .IDX(SW-1-i)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .adv(adv),
            .ctl_i(sq_ctl[i]), .len_i(sq_len[i]), .mix_i(sq_mix[i]),
            .root_i(sq_root[i]), .rem_i(sq_rem[i]),
            .ctl_o(sq_ctl[i+1]), .len_o(sq_len[i+1]), .mix_o(sq_mix[i+1]),
            .root_o(sq_root[i+1]), .rem_o(sq_rem[i+1])
        );
    end

    // divider setup
    logic [SW-1:0]      s_c;
    logic [SW:0]        den_c;
    logic [3:0]         neg_c, ovf_c;
    logic [3:0][NW-1:0] num_c;
    logic [CW-1:0]      abs_c [4];

    always_comb begin
        s_c   = (sq_root[SW] == '0) ? SW'(1) : sq_root[SW];
        den_c = {s_c, 1'b0};
        for (int l = 0; l < 4; l++) begin
            neg_c[l] = sq_mix[SW][l][CW-1];
            abs_c[l] = neg_c[l] ? CW'(-sq_mix[SW][l]) : sq_mix[SW][l];
            num_c[l] = (NW'(abs_c[l]) << (F+1)) + NW'(s_c);
            ovf_c[l] = CMPW'(num_c[l]) >= (CMPW'(den_c) << QB);
        end
    end

    ctl_t               dv_ctl [QB+1];
    logic [SW:0]        dv_den [QB+1];
    logic [3:0]         dv_neg [QB+1];
    logic [3:0]         dv_ovf [QB+1];
    logic [3:0][NW-1:0] dv_rem [QB+1];
    logic [3:0][QB-1:0] dv_quo [QB+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_ctl[0] <= '0;
        end else if (adv) begin
            dv_ctl[0] <= sq_ctl[SW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_den[0] <= den_c;
            dv_neg[0] <= neg_c;
            dv_ovf[0] <= ovf_c;
            dv_rem[0] <= num_c;
        end
    end

    assign dv_quo[0] = '0;

    for (genvar j = 0; j < QB; j++) begin : g_div
        qnl_div_cell #(.NW(NW), .QB(QB), .SW(SW), .K(QB-1-j)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .adv(adv),
            .ctl_i(dv_ctl[j]), .den_i(dv_den[j]), .neg_i(dv_neg[j]),
            .ovf_i(dv_ovf[j]), .rem_i(dv_rem[j]), .quo_i(dv_quo[j]),
            .ctl_o(dv_ctl[j+1]), .den_o(dv_den[j+1]), .neg_o(dv_neg[j+1]),
            .ovf_o(dv_ovf[j+1]), .rem_o(dv_rem[j+1]), .quo_o(dv_quo[j+1])
        );
    end

    // output register
    logic [3:0][CW-1:0] res_c;
    logic [QB-1:0]      qs_c [4];
    logic               m_tvalid_reg, m_tuser_reg;
    logic [OW-1:0]      m_tdata_reg;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            qs_c[l] = (dv_ovf[QB][l] || dv_quo[QB][l] > ONE_Q) ? ONE_Q : dv_quo[QB][l];
            res_c[l] = dv_neg[QB][l] ? CW'(-CW'(qs_c[l])) : CW'(qs_c[l]);
        end
        if (dv_ctl[QB].degen) begin
            res_c[0] = '0;
            res_c[1] = '0;
            res_c[2] = '0;
            res_c[3] = ONE_C;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dv_ctl[QB].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= OW'(res_c);
            m_tuser_reg <= dv_ctl[QB].degen;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    logic signed [CW-1:0] out_c [4];
    for (genvar l = 0; l < 4; l++) begin : g_out
        assign out_c[l] = $signed(m_tdata_reg[l*CW +: CW]);
    end

`ifndef SYNTHESIS
    a_degen_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> out_c[0] == '0 && out_c[1] == '0 && out_c[2] == '0
            && out_c[3] == $signed(ONE_C))
        else $error("degenerate word is not identity");
    a_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata_reg[4*CW-1:0] != '0)
        else $error("normalized word is all zero");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_c[0] <= $signed(ONE_C) && out_c[0] >= -$signed(ONE_C)
            && out_c[1] <= $signed(ONE_C) && out_c[1] >= -$signed(ONE_C)
            && out_c[2] <= $signed(ONE_C) && out_c[2] >= -$signed(ONE_C)
            && out_c[3] <= $signed(ONE_C) && out_c[3] >= -$signed(ONE_C))
        else $error("component outside unit range");
`endif

endmodule
